// ----- hdl/rcp_pkg.sv -----
package rcp_pkg;

	localparam int IdBytes    = 20;
	localparam int BaseHeader = 80;
	localparam int PartHeader = 12;
	localparam int PosW       = 7;

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_PARTHDR,
		PH_DATA
	} phase_t;

	typedef enum logic [2:0] {
		KIND_ID,
		KIND_PHDR,
		KIND_PDONE,
		KIND_DATA,
		KIND_IGNORED
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK,
		ST_SHORT,
		ST_TRUNC,
		ST_OVERRUN,
		ST_ORDER
	} status_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  byte_out;
		logic [2:0]  id_slot;
		logic [4:0]  id_byte_index;
		logic [31:0] part_start;
		logic [31:0] part_end;
		logic [31:0] part_length;
		logic        chunk_done;
		status_t     status;
	} result_t;

	// position / 20 by compare chain
	function automatic logic [2:0] id_slot_of(input logic [PosW-1:0] pos);
		logic [2:0] s;
		s = 3'd0;
		for (int i = 1; i < 7; i++) begin
			if (pos >= PosW'(i * IdBytes))
				s = 3'(i);
		end
		return s;
	endfunction

	function automatic logic [4:0] id_index_of(input logic [PosW-1:0] pos);
		logic [PosW-1:0] r;
		r = pos - PosW'(id_slot_of(pos) * IdBytes);
		return r[4:0];
	endfunction

endpackage

// ----- hdl/rcp_parser.sv -----
module rcp_parser (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic [7:0]       data_byte,
	input  logic             last_byte,
	input  logic             delta_in_stream,
	output rcp_pkg::result_t res
);

	rcp_pkg::phase_t             phase_q, phase_n;
	logic [rcp_pkg::PosW-1:0]    position_q, position_n;
	logic [31:0]                 start_q, start_n;
	logic [31:0]                 end_q, end_n;
	logic [31:0]                 length_q, length_n;
	logic [31:0]                 remaining_q, remaining_n;
	logic                        failed_q, failed_n;

	logic [rcp_pkg::PosW-1:0]    hdr_len;
	logic [rcp_pkg::PosW-1:0]    pos_inc;
	logic [3:0]                  p;

	assign hdr_len = delta_in_stream ? rcp_pkg::PosW'(rcp_pkg::BaseHeader + rcp_pkg::IdBytes)
	                                 : rcp_pkg::PosW'(rcp_pkg::BaseHeader);
	assign pos_inc = position_q + 1'b1;
	assign p       = position_q[3:0];

	always_comb begin
		phase_n     = phase_q;
		position_n  = position_q;
		start_n     = start_q;
		end_n       = end_q;
		length_n    = length_q;
		remaining_n = remaining_q;
		failed_n    = failed_q;

		res.kind          = rcp_pkg::KIND_IGNORED;
		res.byte_out      = data_byte;
		res.id_slot       = 3'd0;
		res.id_byte_index = 5'd0;
		res.chunk_done    = last_byte;
		res.status        = rcp_pkg::ST_OK;

		if (!failed_q) begin
			case (phase_q)
				rcp_pkg::PH_HEADER: begin
					res.kind          = rcp_pkg::KIND_ID;
					res.id_slot       = rcp_pkg::id_slot_of(position_q);
					res.id_byte_index = rcp_pkg::id_index_of(position_q);
					position_n        = pos_inc;
					if (pos_inc >= hdr_len) begin
						phase_n    = rcp_pkg::PH_PARTHDR;
						position_n = '0;
						start_n    = '0;
						end_n      = '0;
						length_n   = '0;
					end else if (last_byte) begin
						res.status = rcp_pkg::ST_SHORT;
					end
				end
				rcp_pkg::PH_PARTHDR: begin
					if (p == 4'd0) begin
						start_n  = '0;
						end_n    = '0;
						length_n = '0;
					end
					if (p < 4'd4)
						start_n = {start_n[23:0], data_byte};
					else if (p < 4'd8)
						end_n = {end_n[23:0], data_byte};
					else
						length_n = {length_n[23:0], data_byte};
					if (p == 4'(rcp_pkg::PartHeader - 1)) begin
						res.kind   = rcp_pkg::KIND_PDONE;
						position_n = '0;
						if (start_n > end_n) begin
							res.status = rcp_pkg::ST_ORDER;
						end else if (length_n == 32'd0) begin
							phase_n = rcp_pkg::PH_PARTHDR;
						end else begin
							phase_n     = rcp_pkg::PH_DATA;
							remaining_n = length_n;
							if (last_byte)
								res.status = rcp_pkg::ST_OVERRUN;
						end
					end else begin
						res.kind   = rcp_pkg::KIND_PHDR;
						position_n = rcp_pkg::PosW'(p + 4'd1);
						if (last_byte)
							res.status = rcp_pkg::ST_TRUNC;
					end
				end
				rcp_pkg::PH_DATA: begin
					res.kind    = rcp_pkg::KIND_DATA;
					remaining_n = remaining_q - 32'd1;
					if (remaining_n == 32'd0) begin
						phase_n    = rcp_pkg::PH_PARTHDR;
						position_n = '0;
					end else if (last_byte) begin
						res.status = rcp_pkg::ST_OVERRUN;
					end
				end
				default: begin
					res.kind = rcp_pkg::KIND_IGNORED;
				end
			endcase
		end

		res.part_start  = start_n;
		res.part_end    = end_n;
		res.part_length = length_n;

		if (res.status != rcp_pkg::ST_OK)
			failed_n = 1'b1;
		if (last_byte) begin
			phase_n     = rcp_pkg::PH_HEADER;
			position_n  = '0;
			start_n     = '0;
			end_n       = '0;
			length_n    = '0;
			remaining_n = '0;
			failed_n    = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= rcp_pkg::PH_HEADER;
			position_q  <= '0;
			start_q     <= '0;
			end_q       <= '0;
			length_q    <= '0;
			remaining_q <= '0;
			failed_q    <= 1'b0;
		end else if (accept) begin
			phase_q     <= phase_n;
			position_q  <= position_n;
			start_q     <= start_n;
			end_q       <= end_n;
			length_q    <= length_n;
			remaining_q <= remaining_n;
			failed_q    <= failed_n;
		end
	end

endmodule

// ----- hdl/revision_chunk_parser_unit.sv -----
// Revision chunk parser: takes one chunk byte per request and returns one tagged result per
// byte (id byte with slot/index, part header byte, part header complete, part data, or
// ignored), along with the part header words and an error status on the byte where an error
// is found. One byte is accepted every cycle while in_stall is low; its result is loaded into
// the output register on acceptance. Throughput is set by the single result register:
// in_stall is high only while a result is held and out_stall is high. delta_in_stream selects a
// 100-byte id header instead of 80 bytes and should be written between chunks.
module revision_chunk_parser_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic        cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  kind,
	output logic [7:0]  byte_out,
	output logic [2:0]  id_slot,
	output logic [4:0]  id_byte_index,
	output logic [31:0] part_start,
	output logic [31:0] part_end,
	output logic [31:0] part_length,
	output logic        chunk_done,
	output logic [2:0]  status
);

	logic             delta_q;
	logic             out_valid_q;
	logic             accept;
	rcp_pkg::result_t res;
	rcp_pkg::result_t res_q;

	assign in_stall = out_valid_q & out_stall;
	assign accept   = in_valid & ~in_stall;

	rcp_parser u_parser (
		.clk             (clk),
		.arst_n          (arst_n),
		.accept          (accept),
		.data_byte       (data_byte),
		.last_byte       (last_byte),
		.delta_in_stream (delta_q),
		.res             (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delta_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wen)
				delta_q <= cfg_wdata;
			if (accept)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			res_q <= res;
	end

	assign out_valid     = out_valid_q;
	assign kind          = res_q.kind;
	assign byte_out      = res_q.byte_out;
	assign id_slot       = res_q.id_slot;
	assign id_byte_index = res_q.id_byte_index;
	assign part_start    = res_q.part_start;
	assign part_end      = res_q.part_end;
	assign part_length   = res_q.part_length;
	assign chunk_done    = res_q.chunk_done;
	assign status        = res_q.status;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

	localparam int ItemTarget = 1450;
	localparam int QuietLimit = 5000;
	localparam int LongHold   = 400;

	class chunk_tracker;
		logic              delta_id;
		rcp_pkg::phase_t   phase;
		logic [6:0]        pos;
		logic [31:0]       start_w;
		logic [31:0]       end_w;
		logic [31:0]       len_w;
		logic [31:0]       remaining;
		logic              failed;
		rcp_pkg::result_t  expected_tags[$];
		int                mismatches;

		function new();
			delta_id = 1'b0;
			mismatches = 0;
			restart_chunk();
		endfunction

		function void restart_chunk();
			phase = rcp_pkg::PH_HEADER;
			pos = '0;
			start_w = '0;
			end_w = '0;
			len_w = '0;
			remaining = '0;
			failed = 1'b0;
		endfunction

		function string tag_text(rcp_pkg::result_t t);
			return $sformatf({"kind %0d byte %02h slot %0d idx %0d start %08h end %08h",
				" len %08h done %0b st %0d"},
				t.kind, t.byte_out, t.id_slot, t.id_byte_index, t.part_start, t.part_end,
				t.part_length, t.chunk_done, t.status);
		endfunction

		function void flag(string what);
			mismatches++;
			if (mismatches <= 10)
				$display("[%0t] %s", $time, what);
		endfunction

		// works out the tag of one accepted request and queues it
		function void parse_request(logic [7:0] b, logic lst);
			rcp_pkg::result_t r;
			int               hdr_len;
			int               p;
			r = '0;
			r.kind = rcp_pkg::KIND_IGNORED;
			r.byte_out = b;
			r.chunk_done = lst;
			r.status = rcp_pkg::ST_OK;
			hdr_len = rcp_pkg::BaseHeader + (delta_id ? rcp_pkg::IdBytes : 0);
			if (!failed) begin
				case (phase)
					rcp_pkg::PH_HEADER: begin
						r.kind = rcp_pkg::KIND_ID;
						r.id_slot = 3'(int'(pos) / rcp_pkg::IdBytes);
						r.id_byte_index = 5'(int'(pos) % rcp_pkg::IdBytes);
						pos = pos + 7'd1;
						if (int'(pos) >= hdr_len) begin
							phase = rcp_pkg::PH_PARTHDR;
							pos = '0;
							start_w = '0;
							end_w = '0;
							len_w = '0;
						end else if (lst) begin
							r.status = rcp_pkg::ST_SHORT;
						end
					end
					rcp_pkg::PH_PARTHDR: begin
						p = int'(pos) % rcp_pkg::PartHeader;
						if (p == 0) begin
							start_w = '0;
							end_w = '0;
							len_w = '0;
						end
						if (p < 4)
							start_w = {start_w[23:0], b};
						else if (p < 8)
							end_w = {end_w[23:0], b};
						else
							len_w = {len_w[23:0], b};
						if (p == rcp_pkg::PartHeader - 1) begin
							r.kind = rcp_pkg::KIND_PDONE;
							pos = '0;
							if (start_w > end_w) begin
								r.status = rcp_pkg::ST_ORDER;
							end else if (len_w != 0) begin
								phase = rcp_pkg::PH_DATA;
								remaining = len_w;
								if (lst)
									r.status = rcp_pkg::ST_OVERRUN;
							end
						end else begin
							r.kind = rcp_pkg::KIND_PHDR;
							pos = 7'(p + 1);
							if (lst)
								r.status = rcp_pkg::ST_TRUNC;
						end
					end
					default: begin
						r.kind = rcp_pkg::KIND_DATA;
						remaining = remaining - 32'd1;
						if (remaining == 0) begin
							phase = rcp_pkg::PH_PARTHDR;
							pos = '0;
						end else if (lst) begin
							r.status = rcp_pkg::ST_OVERRUN;
						end
					end
				endcase
			end
			r.part_start = start_w;
			r.part_end = end_w;
			r.part_length = len_w;
			expected_tags.push_back(r);
			if (r.status != rcp_pkg::ST_OK)
				failed = 1'b1;
			if (lst)
				restart_chunk();
		endfunction

		function void compare_tag(rcp_pkg::result_t got);
			rcp_pkg::result_t want;
			if (expected_tags.size() == 0) begin
				flag({"result with no request pending: ", tag_text(got)});
				return;
			end
			want = expected_tags.pop_front();
			if (got.kind !== want.kind || got.byte_out !== want.byte_out
					|| got.id_slot !== want.id_slot || got.id_byte_index !== want.id_byte_index
					|| got.part_start !== want.part_start || got.part_end !== want.part_end
					|| got.part_length !== want.part_length || got.chunk_done !== want.chunk_done
					|| got.status !== want.status) begin
				flag({"mismatch\n  expected ", tag_text(want), "\n  actual   ", tag_text(got)});
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n = 1'b0;
	logic        cfg_wen = 1'b0;
	logic        cfg_wdata = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = '0;
	logic        last_byte = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  kind;
	logic [7:0]  byte_out;
	logic [2:0]  id_slot;
	logic [4:0]  id_byte_index;
	logic [31:0] part_start;
	logic [31:0] part_end;
	logic [31:0] part_length;
	logic        chunk_done;
	logic [2:0]  status;

	chunk_tracker tracker;
	logic [7:0]   chunk_q[$];
	logic         delta_now = 1'b0;
	logic         long_hold = 1'b0;
	int           quiet_cycles = 0;
	int           sent_count = 0;
	int           burst_left = 0;

	revision_chunk_parser_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wen       (cfg_wen),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.data_byte     (data_byte),
		.last_byte     (last_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.kind          (kind),
		.byte_out      (byte_out),
		.id_slot       (id_slot),
		.id_byte_index (id_byte_index),
		.part_start    (part_start),
		.part_end      (part_end),
		.part_length   (part_length),
		.chunk_done    (chunk_done),
		.status        (status)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin : monitor
		rcp_pkg::result_t got;
		if (arst_n) begin
			if (in_valid && !in_stall)
				tracker.parse_request(data_byte, last_byte);
			if (out_valid && !out_stall) begin
				got.kind = rcp_pkg::kind_t'(kind);
				got.byte_out = byte_out;
				got.id_slot = id_slot;
				got.id_byte_index = id_byte_index;
				got.part_start = part_start;
				got.part_end = part_end;
				got.part_length = part_length;
				got.chunk_done = chunk_done;
				got.status = rcp_pkg::status_t'(status);
				tracker.compare_tag(got);
			end
		end
		if (arst_n && ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wen))
			quiet_cycles = 0;
		else
			quiet_cycles++;
	end

	initial begin : watchdog
		while (quiet_cycles < QuietLimit)
			@(posedge clk);
		$display("no handshake for %0d cycles", QuietLimit);
		$display("TEST FAILED");
		$finish;
	end

	// receiver: random stall stretches, plus a long hold-off on request
	initial begin : receiver
		int stretch;
		int pct;
		forever begin
			if (long_hold) begin
				out_stall <= 1'b1;
				repeat (LongHold) @(posedge clk);
				long_hold = 1'b0;
			end else begin
				stretch = $urandom_range(8, 64);
				case ($urandom_range(0, 3))
					0: pct = 0;
					1: pct = 20;
					2: pct = 50;
					default: pct = 85;
				endcase
				repeat (stretch) begin
					out_stall <= ($urandom_range(0, 99) < pct);
					@(posedge clk);
				end
			end
		end
	end

	task automatic offer_byte(input logic [7:0] b, input logic lst);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 30);
		end
		burst_left--;
		in_valid <= 1'b1;
		data_byte <= b;
		last_byte <= lst;
		do @(posedge clk); while (in_stall);
		sent_count++;
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (tracker.expected_tags.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_delta(input logic v);
		wait_idle();
		cfg_wen <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_wen <= 1'b0;
		tracker.delta_id = v;
		delta_now = v;
	endtask

	task automatic send_span(input int lo, input int hi);
		for (int i = lo; i < hi; i++)
			offer_byte(chunk_q[i], i == chunk_q.size() - 1);
	endtask

	task automatic send_chunk();
		send_span(0, chunk_q.size());
	endtask

	task automatic push_header();
		repeat (rcp_pkg::BaseHeader + (delta_now ? rcp_pkg::IdBytes : 0))
			chunk_q.push_back(8'($urandom));
	endtask

	task automatic push_part(input logic [31:0] s, input logic [31:0] e,
			input logic [31:0] l, input int ndata);
		logic [95:0] w;
		w = {s, e, l};
		for (int k = 11; k >= 0; k--)
			chunk_q.push_back(w[8*k +: 8]);
		repeat (ndata) chunk_q.push_back(8'($urandom));
	endtask

	// mostly well-formed chunks; some truncated, some with start after end, some noise
	task automatic build_random_chunk();
		int          flaw;
		int          nparts;
		int          bad;
		int          len;
		int          ndata;
		int          cut;
		logic [31:0] s;
		logic [31:0] e;
		logic [31:0] t;
		chunk_q.delete();
		flaw = $urandom_range(0, 9);
		if (flaw == 9) begin
			repeat ($urandom_range(1, 120)) chunk_q.push_back(8'($urandom));
			return;
		end
		push_header();
		nparts = $urandom_range((flaw == 8) ? 1 : 0, 5);
		bad = (flaw == 8) ? $urandom_range(0, nparts - 1) : -1;
		for (int i = 0; i < nparts; i++) begin
			if (i == bad) begin
				s = $urandom_range(32'hFFFF_FFFF, 1);
				e = $urandom_range(s - 32'd1, 0);
			end else begin
				s = $urandom;
				e = $urandom;
				if (s > e) begin
					t = s;
					s = e;
					e = t;
				end
				if ($urandom_range(0, 7) == 0)
					e = s;
			end
			case ($urandom_range(0, 9))
				0, 1: len = 0;
				2: len = $urandom_range(13, 48);
				default: len = $urandom_range(1, 12);
			endcase
			ndata = len;
			if (flaw == 7 && i == nparts - 1 && $urandom_range(0, 1) == 1) begin
				len = $urandom;
				ndata = $urandom_range(0, 20);
			end
			push_part(s, e, len, ndata);
		end
		if (flaw == 7) begin
			cut = $urandom_range(1, chunk_q.size());
			while (chunk_q.size() > cut)
				void'(chunk_q.pop_back());
		end
	endtask

	initial begin : stimulus
		int split;
		tracker = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// chunk ends in the id header
		chunk_q.delete();
		chunk_q.push_back(8'hFF);
		send_chunk();
		// chunk ends right after the id header
		chunk_q.delete();
		push_header();
		send_chunk();
		// extreme words, a zero-length part, then ends inside a part header
		chunk_q.delete();
		push_header();
		push_part(32'h0, 32'hFFFF_FFFF, 32'h0, 0);
		push_part(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd2, 2);
		push_part(32'h0, 32'h0, 32'd1, 1);
		repeat (5) chunk_q.push_back(8'($urandom));
		send_chunk();
		// start after end, rest of chunk ignored
		chunk_q.delete();
		push_header();
		push_part(32'hFFFF_FFFF, 32'h0, 32'd5, 5);
		push_part(32'd1, 32'd2, 32'd3, 3);
		send_chunk();
		// part header completes on the last byte with data owed
		chunk_q.delete();
		push_header();
		push_part(32'h0, 32'h0, 32'hFFFF_FFFF, 0);
		send_chunk();
		// same, but start after end takes precedence
		chunk_q.delete();
		push_header();
		push_part(32'd5, 32'd4, 32'd3, 0);
		send_chunk();
		// data runs past the chunk end
		chunk_q.delete();
		push_header();
		push_part(32'd0, 32'd1, 32'd10, 4);
		send_chunk();
		// chunk ends after a whole part
		chunk_q.delete();
		push_header();
		push_part(32'd7, 32'd9, 32'd1, 1);
		send_chunk();
		// header length changed mid-header: shrink past the position, then grow
		write_delta(1'b1);
		chunk_q.delete();
		push_header();
		push_part(32'd1, 32'd3, 32'd2, 2);
		send_span(0, 90);
		write_delta(1'b0);
		send_span(90, chunk_q.size());
		chunk_q.delete();
		push_header();
		push_part(32'd1, 32'd3, 32'd2, 2);
		send_span(0, 50);
		write_delta(1'b1);
		send_span(50, chunk_q.size());

		for (int n = 0; sent_count < ItemTarget; n++) begin
			if (n == 1 || n == 6)
				long_hold = 1'b1;
			if (n == 3)
				wait_idle();
			if ($urandom_range(0, 3) == 0)
				write_delta(1'($urandom_range(0, 1)));
			build_random_chunk();
			if ($urandom_range(0, 7) == 0 && chunk_q.size() > 1) begin
				split = $urandom_range(1, chunk_q.size() - 1);
				send_span(0, split);
				write_delta(!delta_now);
				send_span(split, chunk_q.size());
			end else begin
				send_chunk();
			end
		end

		wait_idle();
		repeat (8) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.expected_tags.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			if (tracker.expected_tags.size() != 0)
				$display("%0d results never arrived", tracker.expected_tags.size());
			$display("%0d mismatches", tracker.mismatches);
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
